FILE: rtl/sfd_pkg.sv
// shared types and constants for the float to decimal digit converter
package sfd_pkg;
    localparam int MANT_W = 24;
    localparam int DIG_W = 4;
    localparam int EXP_W = 7;

    typedef struct packed {
        logic [DIG_W-1:0] digit;
        logic signed [EXP_W-1:0] decimal_exponent;
        logic negative;
        logic not_finite;
        logic last;
    } sfd_result_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCALE_UP,
        OP_SCALE_S,
        OP_DIGIT_MUL,
        OP_DIGIT_SUB,
        OP_FINISH
    } sfd_op_t;

    typedef struct packed {
        sfd_op_t op;
    } sfd_cmd_t;

    typedef struct packed {
        logic special;
        logic r_lt_t;
        logic t_ge_u;
        logic r_ge_s;
        logic stop;
        logic round_up;
    } sfd_status_t;
endpackage

FILE: rtl/sfd_stream_if.sv
// valid/ready channel carrying one payload
interface sfd_stream_if #(parameter int WIDTH = 32);
    logic valid;
    logic ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/sfd_datapath.sv
// big integer registers and compare logic for the digit generator
module sfd_datapath import sfd_pkg::*; #(
    parameter int BIG_WIDTH = 192
) (
    input  logic clk,
    input  logic [31:0] value_bits,
    input  sfd_cmd_t cmd,
    output sfd_status_t status,
    output logic [DIG_W-1:0] digit,
    output logic signed [EXP_W-1:0] exponent,
    output logic negative,
    output logic not_finite
);
    localparam int BW = BIG_WIDTH;
    localparam int XW = 10;

    logic [BW-1:0] r_reg, s_reg, m_reg;
    logic [DIG_W-1:0] d_reg;
    logic signed [EXP_W-1:0] k_reg;
    logic uneq_reg, neg_reg, nf_reg, special_reg;

    // load decode
    logic [7:0] ef;
    logic [22:0] mf;
    logic [MANT_W-1:0] f_norm;
    logic signed [XW-1:0] x_norm;
    logic [4:0] lz;

    always_comb
    begin
        ef = value_bits[30:23];
        mf = value_bits[22:0];
        lz = 5'd0;
        for (int i = 22; i >= 0; i--)
        begin
            if (mf[i] && lz == 5'd0 && !(|(mf >> (i + 1))))
                lz = 5'(22 - i);
        end
        if (ef == 8'd0)
        begin
            f_norm = MANT_W'({1'b0, mf} << (lz + 5'd1));
            x_norm = XW'(-149) - XW'(lz) - XW'(1);
        end
        else
        begin
            f_norm = {1'b1, mf};
            x_norm = XW'(signed'({2'b0, ef})) - XW'(150);
        end
    end

    logic [BW-1:0] r10, m10, s10, r2m, s2, r2, r4, r_sub;
    assign r10 = (r_reg << 3) + (r_reg << 1);
    assign m10 = (m_reg << 3) + (m_reg << 1);
    assign s10 = (s_reg << 3) + (s_reg << 1);
    assign r2 = r_reg << 1;
    assign r4 = r_reg << 2;
    assign r2m = r2 + m_reg;
    assign s2 = s_reg << 1;
    assign r_sub = r_reg - s_reg;

    logic low, high;
    always_comb
    begin
        low = (uneq_reg ? r4 : r2) < m_reg;
        high = r2m > s2;
        status.special = special_reg;
        // r < ceil(s/10) holds exactly when 10r < s
        status.r_lt_t = r10 < s_reg;
        status.t_ge_u = r2m >= s2;
        status.r_ge_s = (r_reg >= s_reg) && (d_reg < 4'd15);
        status.stop = low || high;
        if (high && !low)
            status.round_up = 1'b1;
        else if (low && !high)
            status.round_up = 1'b0;
        else
            status.round_up = r2 > s_reg;
    end

    logic [BW-1:0] s_load;
    logic [XW-1:0] sneg;
    always_comb
    begin
        sneg = x_norm < 0 ? XW'(-x_norm) : '0;
        s_load = BW'(1) << sneg;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                neg_reg <= value_bits[31];
                nf_reg <= (ef == 8'hFF);
                special_reg <= (ef == 8'hFF) || (ef == 8'd0 && mf == 23'd0);
                uneq_reg <= (f_norm == MANT_W'(1) << (MANT_W - 1));
                r_reg <= BW'(f_norm) << (x_norm > 0 ? x_norm : XW'(0));
                m_reg <= BW'(1) << (x_norm > 0 ? x_norm : XW'(0));
                s_reg <= s_load;
                k_reg <= '0;
                d_reg <= '0;
            end
            OP_SCALE_UP:
            begin
                r_reg <= r10;
                m_reg <= m10;
                k_reg <= k_reg - EXP_W'(1);
            end
            OP_SCALE_S:
            begin
                s_reg <= s10;
                k_reg <= k_reg + EXP_W'(1);
            end
            OP_DIGIT_MUL:
            begin
                r_reg <= r10;
                m_reg <= m10;
                d_reg <= '0;
            end
            OP_DIGIT_SUB:
            begin
                r_reg <= r_sub;
                d_reg <= d_reg + DIG_W'(1);
            end
            OP_FINISH:
                d_reg <= d_reg + DIG_W'(status.round_up);
            default:
            begin
            end
        endcase
    end

    assign digit = special_reg ? '0 : d_reg;
    assign exponent = special_reg ? '0 : k_reg - EXP_W'(1);
    assign negative = neg_reg;
    assign not_finite = nf_reg;
endmodule

FILE: rtl/sfd_control.sv
// sequencer for the scaling and digit generation steps
module sfd_control import sfd_pkg::*; #(
    parameter int MAX_DIGITS = 9
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output logic out_last,
    input  sfd_status_t status,
    output sfd_cmd_t cmd
);
    localparam int NW = $clog2(MAX_DIGITS + 1);
    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_UP, S_SC, S_MUL, S_SUB, S_EMIT, S_FIN
    } state_t;
    state_t state_reg;
    logic [NW-1:0] n_reg;
    logic valid_reg, last_reg;
    logic cap;

    assign cap = (32'(n_reg) + 32'd1) >= 32'(MAX_DIGITS);
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = valid_reg;
    assign out_last = last_reg;

    always_comb
    begin
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE: if (in_valid) cmd.op = OP_LOAD;
            S_UP: if (status.r_lt_t) cmd.op = OP_SCALE_UP;
            S_SC: if (status.t_ge_u) cmd.op = OP_SCALE_S;
            S_MUL: if (!valid_reg) cmd.op = OP_DIGIT_MUL;
            S_SUB: if (status.r_ge_s) cmd.op = OP_DIGIT_SUB;
            S_FIN: cmd.op = OP_FINISH;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg <= '0;
            valid_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (valid_reg && out_ready)
                valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        state_reg <= S_CHECK;
                        n_reg <= '0;
                    end
                S_CHECK:
                    if (status.special)
                    begin
                        valid_reg <= 1'b1;
                        last_reg <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_UP;
                S_UP: if (!status.r_lt_t) state_reg <= S_SC;
                S_SC: if (!status.t_ge_u) state_reg <= S_MUL;
                S_MUL: if (!valid_reg) state_reg <= S_SUB;
                S_SUB:
                    if (!status.r_ge_s)
                    begin
                        if (status.stop || cap)
                            state_reg <= S_FIN;
                        else
                        begin
                            valid_reg <= 1'b1;
                            last_reg <= 1'b0;
                            n_reg <= n_reg + NW'(1);
                            state_reg <= S_MUL;
                        end
                    end
                S_FIN:
                begin
                    valid_reg <= 1'b1;
                    last_reg <= 1'b1;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                    if (valid_reg && out_ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/shortest_float_to_decimal_digits.sv
// top level: shortest decimal digits of a single-precision float
// zero, infinity and nan skip the scaling and digit steps and go straight to the result; otherwise
// the steps are the multiplies by ten in the scaling loops (up to about 45), and per digit
// one multiply, the subtracts (up to 9) and one check, plus out_ch stalls
// throughput: one request at a time, next accepted the cycle after the last digit is taken
// reset: asynchronous active low, clears the sequencer and output valid
module shortest_float_to_decimal_digits import sfd_pkg::*; #(
    parameter int BIG_WIDTH = 192,
    parameter int MAX_DIGITS = 9
) (
    input logic clk,
    input logic rst_n,
    sfd_stream_if.sink in_ch,
    sfd_stream_if.source out_ch
);
    sfd_cmd_t cmd;
    sfd_status_t status;
    sfd_result_t res;
    logic last;

    sfd_control #(.MAX_DIGITS(MAX_DIGITS)) u_ctl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_last(last), .status(status), .cmd(cmd)
    );

    sfd_datapath #(.BIG_WIDTH(BIG_WIDTH)) u_dp (
        .clk(clk), .value_bits(in_ch.data[31:0]), .cmd(cmd), .status(status),
        .digit(res.digit), .exponent(res.decimal_exponent),
        .negative(res.negative), .not_finite(res.not_finite)
    );

    assign res.last = last;
    assign out_ch.data = 14'(res);
endmodule
